// ===== src/bhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types and codes for the binary min-heap priority queue: entry
// layout, operation and status codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bhq_pkg;

  localparam int DATA_W  = 8;
  localparam int PRIO_W  = 16;
  localparam int ENTRY_W = DATA_W + PRIO_W;
  localparam int STAT_W  = 2;
  localparam int COUNT_OUT_W = 8;

  // Operation codes on the op port.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // One heap slot: priority in the upper bits, data in the lower bits.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_DEL_LOAD,
    S_DEL_CHK,
    S_DEL_CMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;    // capture the incoming item
    logic fail_full;    // report insert on a full heap
    logic fail_empty;   // report remove on an empty heap
    logic init_ins;     // position := count + 1
    logic ins_rd;       // read the parent of the current position
    logic ins_move;     // move the parent down to the current position
    logic ins_place;    // write the new item at the current position
    logic del_rd_root;  // read the root and the last slot
    logic del_load;     // latch root data and last entry, position := root
    logic del_rd_kids;  // read both children of the current position
    logic del_move;     // move the chosen child up to the current position
    logic del_place;    // write the last entry at the current position
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_full;
    logic is_zero;
    logic at_root;
    logic less_parent;
    logic no_child;
    logic last_le_child;
  } dp_stat_t;

endpackage

// ===== src/bhq_ram.sv =====
// ----------------------------------------------------------------------------
// bhq_ram
// Generic RAM with one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Synchronous write and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== src/bhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bhq_ctrl
// Controller state machine: sequences the sift-up of an insert and the
// sift-down of a remove, with a check state and a compare state per heap level.
// ----------------------------------------------------------------------------
module bhq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             op,
  input  bhq_pkg::dp_stat_t stat,
  output bhq_pkg::dp_cmd_t  cmd,
  output logic             busy
);
  import bhq_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_INSERT) begin
            state_next = stat.is_full ? S_IDLE : S_INS_CHK;
          end else begin
            state_next = stat.is_zero ? S_IDLE : S_DEL_LOAD;
          end
        end
      end
      S_INS_CHK:  state_next = stat.at_root ? S_IDLE : S_INS_CMP;
      S_INS_CMP:  state_next = stat.less_parent ? S_INS_CHK : S_IDLE;
      S_DEL_LOAD: state_next = S_DEL_CHK;
      S_DEL_CHK:  state_next = stat.no_child ? S_IDLE : S_DEL_CMP;
      S_DEL_CMP:  state_next = stat.last_le_child ? S_IDLE : S_DEL_CHK;
      default:    state_next = S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          if (op == OP_INSERT) begin
            if (stat.is_full) cmd.fail_full = 1'b1;
            else              cmd.init_ins  = 1'b1;
          end else begin
            if (stat.is_zero) cmd.fail_empty  = 1'b1;
            else              cmd.del_rd_root = 1'b1;
          end
        end
      end
      S_INS_CHK: begin
        if (stat.at_root) cmd.ins_place = 1'b1;
        else              cmd.ins_rd    = 1'b1;
      end
      S_INS_CMP: begin
        if (stat.less_parent) cmd.ins_move  = 1'b1;
        else                  cmd.ins_place = 1'b1;
      end
      S_DEL_LOAD: cmd.del_load = 1'b1;
      S_DEL_CHK: begin
        if (stat.no_child) cmd.del_place   = 1'b1;
        else               cmd.del_rd_kids = 1'b1;
      end
      S_DEL_CMP: begin
        if (stat.last_le_child) cmd.del_place = 1'b1;
        else                    cmd.del_move  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== src/bhq_dp.sv =====
// ----------------------------------------------------------------------------
// bhq_dp
// Datapath: heap memory, position and count registers, the compares of the
// sift loops and the result registers.
// ----------------------------------------------------------------------------
module bhq_dp #(
  parameter int CAPACITY = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bhq_pkg::dp_cmd_t               cmd,
  output bhq_pkg::dp_stat_t              stat,
  input  logic [bhq_pkg::DATA_W-1:0]     item_data,
  input  logic [bhq_pkg::PRIO_W-1:0]     item_priority,
  output logic                           done,
  output logic [bhq_pkg::DATA_W-1:0]     removed_data,
  output logic [bhq_pkg::STAT_W-1:0]     status,
  output logic [bhq_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                           is_empty
);
  import bhq_pkg::*;

  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = (AW > COUNT_OUT_W) ? AW : COUNT_OUT_W;
  localparam logic [AW-1:0] ROOT = AW'(1);
  localparam logic [AW-1:0] CAP  = AW'(CAPACITY);

  entry_t          item;
  entry_t          last;
  logic [DATA_W-1:0] root_data;
  logic [AW-1:0]   pos;
  logic [AW-1:0]   count;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic [AW-1:0]   raddr0;
  logic [AW-1:0]   raddr1;
  logic [ENTRY_W-1:0] rdata0;
  logic [ENTRY_W-1:0] rdata1;
  entry_t          rd0;
  entry_t          rd1;

  logic [AW:0]     left_idx;
  logic [AW:0]     right_idx;
  logic            has_right;
  logic            pick_right;
  entry_t          child;
  logic [AW-1:0]   child_idx;
  logic [AW-1:0]   parent;
  logic            finish;
  logic [EW-1:0]   count_ext;

  assign rd0 = entry_t'(rdata0);
  assign rd1 = entry_t'(rdata1);

  // Tree addressing around the current position.
  assign parent    = pos >> 1;
  assign left_idx  = {pos, 1'b0};
  assign right_idx = left_idx + 1'b1;
  assign has_right = (right_idx <= {1'b0, count});

  // Smaller child, left one on equal priorities.
  assign pick_right = has_right && (rd0.prio > rd1.prio);
  assign child      = pick_right ? rd1 : rd0;
  assign child_idx  = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  // Status toward the controller.
  assign stat.is_full       = (count == CAP);
  assign stat.is_zero       = (count == '0);
  assign stat.at_root       = (pos == ROOT);
  assign stat.less_parent   = (item.prio < rd0.prio);
  assign stat.no_child      = (left_idx > {1'b0, count});
  assign stat.last_le_child = (last.prio <= child.prio);

  // Read addresses: root and last slot, parent, or both children.
  always_comb begin
    if (cmd.del_rd_root) begin
      raddr0 = ROOT;
      raddr1 = count;
    end else if (cmd.ins_rd) begin
      raddr0 = parent;
      raddr1 = parent;
    end else if (cmd.del_rd_kids) begin
      raddr0 = left_idx[AW-1:0];
      raddr1 = has_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    end else begin
      raddr0 = ROOT;
      raddr1 = ROOT;
    end
  end

  // Write port: every write lands on the current position.
  always_comb begin
    we    = cmd.ins_move | cmd.ins_place | cmd.del_move | cmd.del_place;
    waddr = pos;
    if (cmd.ins_move)       wdata = rd0;
    else if (cmd.ins_place) wdata = item;
    else if (cmd.del_move)  wdata = child;
    else                    wdata = last;
  end

  bhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Item, last entry and removed data capture.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item.data <= item_data;
      item.prio <= item_priority;
    end
    if (cmd.del_load) begin
      root_data <= rd0.data;
      last      <= rd1;
    end
  end

  // Current position in the tree.
  always_ff @(posedge clk) begin
    if (cmd.init_ins)      pos <= count + 1'b1;
    else if (cmd.ins_move) pos <= parent;
    else if (cmd.del_load) pos <= ROOT;
    else if (cmd.del_move) pos <= child_idx;
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins_place) begin
      count <= count + 1'b1;
    end else if (cmd.del_place) begin
      count <= count - 1'b1;
    end
  end

  // Result registers, loaded as each item finishes.
  assign finish = cmd.ins_place | cmd.del_place | cmd.fail_full | cmd.fail_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      removed_data <= cmd.del_place ? root_data : '0;
      if (cmd.fail_full)       status <= ST_FULL;
      else if (cmd.fail_empty) status <= ST_EMPTY;
      else                     status <= ST_OK;
    end
  end

  assign count_ext   = EW'(count);
  assign entry_count = count_ext[COUNT_OUT_W-1:0];
  assign is_empty    = (count == '0);

endmodule

// ===== src/binary_min_heap_queue_unit.sv =====
// An insert alternates a check and a compare state per heap level moved; a remove first
// loads the root and last entry, then does the same. At most log2(CAPACITY) levels move.
// An insert that reaches the root, or a remove that reaches a slot with no children,
// places its item from the check state with no compare. A failed insert or remove
// reports done in the next cycle. Throughput is one item at a time; each level costs
// one read and one write. Reset clears the count and the controller; heap memory is not cleared.
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit
// Priority queue kept as a 1-indexed binary min-heap in a RAM, with a
// controller state machine sequencing the sift-up and sift-down loops.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit #(
  parameter int CAPACITY = 255
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op,
  input  logic [bhq_pkg::DATA_W-1:0]      item_data,
  input  logic [bhq_pkg::PRIO_W-1:0]      item_priority,
  output logic                            done,
  output logic [bhq_pkg::DATA_W-1:0]      removed_data,
  output logic [bhq_pkg::STAT_W-1:0]      status,
  output logic [bhq_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                            is_empty
);
  import bhq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  bhq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Heap storage and arithmetic.
  bhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item_data     (item_data),
    .item_priority (item_priority),
    .done          (done),
    .removed_data  (removed_data),
    .status        (status),
    .entry_count   (entry_count),
    .is_empty      (is_empty)
  );

  // A result only appears once the controller is back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  // An accepted item either starts work or fails at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor finished");

  // A failed operation returns no data.
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (removed_data == '0))
    else $error("failed operation returned data");

  // An insert on a full heap leaves the count unchanged.
  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == $past(entry_count)))
    else $error("count changed on insert to a full heap");

endmodule
